// ----- hdl/ffpa_pkg.sv -----
// Shared constants and helpers for the first-free page allocator.
// The page table row layout and the slot priority pick live here; no dependencies.
`default_nettype none

package ffpa_pkg;

	localparam int NUM_PAGES  = 512;
	localparam int PAGE_SHIFT = 12;
	localparam int ADDR_W     = 32;
	localparam int OWNER_W    = 8;
	localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;

	// One table row holds the in-use marks and owners of SLOTS pages.
	localparam int SLOTS    = 8;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int ROWS     = (NUM_PAGES + SLOTS - 1) / SLOTS;
	localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ROWC_W   = $clog2(ROWS + 1);
	localparam int PN_W     = ROW_W + SLOT_W;
	localparam int ROW_BITS = SLOTS * (OWNER_W + 1);

	// Lowest set bit of a slot vector; the caller checks that one is set.
	function automatic logic [SLOT_W-1:0] first_free(input logic [SLOTS-1:0] v);
		logic [SLOT_W-1:0] idx;
		idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = SLOT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/ffpa_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; no package dependencies.
`default_nettype none

module ffpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/first_free_page_allocator_core.sv -----
// First-free page allocator core: page table in one row-wide RAM; uses ffpa_pkg, ffpa_ram.
// Flow: an accepted request has its table row fetched and evaluated in S_EVAL, then waits
// in S_DONE for the output register (a request refused at decode goes straight to S_DONE);
// a first-free search takes one more S_EVAL pass for each fully used row it steps over (at
// most ROWS - 1). The RAM read-evaluate-write loop holds one request in flight at a time.
// Reset: a clearing pass zeroes every row (64 here); no request is taken.
`default_nettype none

module first_free_page_allocator_core
	import ffpa_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                req_type,
	input  wire logic [ADDR_W-1:0]   page_address,
	input  wire logic signed [OWNER_W-1:0] owner_id,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     status,
	output logic [ADDR_W-1:0]        claimed_address
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL,
		S_DONE
	} state_t;

	state_t state_q;

	// Request context held while the table row is fetched and evaluated.
	logic               type_q;
	logic [OWNER_W-1:0] owner_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [ROW_W-1:0]   cur_row_q;

	// All rows below scan_row_q are fully used. Pages are never released, so this
	// pointer only moves forward and a first-free search can start there.
	logic [ROWC_W-1:0]  scan_row_q;
	logic [ROW_W-1:0]   clr_row_q;

	// Result waiting in S_DONE, and the output register that the consumer sees.
	logic               res_status_q;
	logic [ADDR_W-1:0]  res_addr_q;
	logic               out_valid_q;
	logic               status_q;
	logic [ADDR_W-1:0]  claimed_q;

	// Table RAM ports.
	logic                ram_we;
	logic [ROW_W-1:0]    ram_waddr;
	logic [ROW_BITS-1:0] ram_wdata;
	logic                ram_re;
	logic [ROW_W-1:0]    ram_raddr;
	logic [ROW_BITS-1:0] ram_rdata;

	// Decode of an incoming request.
	logic                accept;
	logic                t1_bad;
	logic                t0_full;
	logic [ROW_W-1:0]    in_row;

	// Evaluation of the fetched row.
	logic [SLOTS-1:0]    rd_use;
	logic [SLOTS-1:0]    free_vec;
	logic                found;
	logic [SLOT_W-1:0]   sel_slot;
	logic                claim_ok;
	logic [ROWC_W-1:0]   nxt_row;
	logic                scan_end;
	logic [63:0]         addr_wide;
	logic [ROW_BITS-1:0] row_upd;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// A directed claim fails at once on a set offset bit or a page past memory.
	assign t1_bad = (page_address[PAGE_SHIFT-1:0] != '0) ||
		({1'b0, page_address[ADDR_W-1:PAGE_SHIFT]} >= (PAGE_NUM_W+1)'(NUM_PAGES));
	assign t0_full = (scan_row_q == ROWC_W'(ROWS));
	assign in_row  = req_type ? page_address[PAGE_SHIFT+SLOT_W +: ROW_W]
	                          : scan_row_q[ROW_W-1:0];

	// A row holds the in-use marks in its low bits and the owners above them. A
	// page is free when its mark is clear and its owner field is zero; slots past the
	// last page in a partial final row never count as free.
	always_comb begin
		rd_use = ram_rdata[SLOTS-1:0];
		for (int i = 0; i < SLOTS; i++) begin
			free_vec[i] = !rd_use[i] &&
				(ram_rdata[SLOTS + OWNER_W*i +: OWNER_W] == '0) &&
				((PN_W+1)'({cur_row_q, SLOT_W'(i)}) < (PN_W+1)'(NUM_PAGES));
		end
	end

	assign found    = |free_vec;
	assign sel_slot = type_q ? slot_q : first_free(free_vec);
	// Directed claims test only the in-use mark, never the owner.
	assign claim_ok = type_q ? !rd_use[slot_q] : found;
	assign nxt_row  = ROWC_W'(cur_row_q) + ROWC_W'(1);
	assign scan_end = (nxt_row == ROWC_W'(ROWS));

	// Byte address of the claimed page, kept to the low 32 bits.
	assign addr_wide = 64'({cur_row_q, sel_slot}) << PAGE_SHIFT;

	// Read-modify-write of the fetched row: set the mark, record the owner.
	always_comb begin
		row_upd = ram_rdata;
		row_upd[sel_slot] = 1'b1;
		row_upd[SLOTS + OWNER_W*sel_slot +: OWNER_W] = owner_q;
	end

	// RAM control. The clearing pass zeroes one row a cycle; otherwise the only
	// write is the claim in S_EVAL. A read is issued when a request is accepted and not
	// refused at decode and, during a first-free search, for the next row while the
	// current one misses. Each write lands before the next read of any row is issued,
	// so no forwarding is needed.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_row_q;
		ram_wdata = row_upd;
		ram_re    = 1'b0;
		ram_raddr = in_row;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_row_q;
				ram_wdata = '0;
			end
			S_IDLE: begin
				ram_re = accept && (req_type ? !t1_bad : !t0_full);
			end
			S_EVAL: begin
				ram_we    = claim_ok;
				ram_raddr = nxt_row[ROW_W-1:0];
				ram_re    = !type_q && !found && !scan_end;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	ffpa_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(ROWS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_row_q    <= '0;
			scan_row_q   <= '0;
			out_valid_q  <= 1'b0;
			type_q       <= 1'b0;
			owner_q      <= '0;
			slot_q       <= '0;
			cur_row_q    <= '0;
			res_status_q <= 1'b0;
			res_addr_q   <= '0;
			status_q     <= 1'b0;
			claimed_q    <= '0;
		end else begin
			// In S_DONE the hand-over below decides the output register's valid bit.
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_row_q <= clr_row_q + ROW_W'(1);
					if (clr_row_q == ROW_W'(ROWS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						type_q    <= req_type;
						owner_q   <= $unsigned(owner_id);
						slot_q    <= page_address[PAGE_SHIFT +: SLOT_W];
						cur_row_q <= in_row;
						if (req_type ? t1_bad : t0_full) begin
							res_status_q <= 1'b1;
							res_addr_q   <= '0;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_EVAL;
						end
					end
				end
				S_EVAL: begin
					if (claim_ok) begin
						res_status_q <= 1'b0;
						res_addr_q   <= addr_wide[ADDR_W-1:0];
						if (!type_q) begin
							scan_row_q <= ROWC_W'(cur_row_q);
						end
						state_q <= S_DONE;
					end else if (type_q) begin
						res_status_q <= 1'b1;
						res_addr_q   <= '0;
						state_q      <= S_DONE;
					end else begin
						// This row is full for good; step the search pointer past it.
						scan_row_q <= nxt_row;
						if (scan_end) begin
							res_status_q <= 1'b1;
							res_addr_q   <= '0;
							state_q      <= S_DONE;
						end else begin
							cur_row_q <= nxt_row[ROW_W-1:0];
						end
					end
				end
				S_DONE: begin
					// Hand the result over once the output register is free or
					// being emptied this cycle.
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						claimed_q   <= res_addr_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign claimed_address = claimed_q;

	// The search pointer never moves backward once the table is cleared.
	a_scan_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |=> (scan_row_q >= $past(scan_row_q)))
		else $error("search pointer moved backward");

	// A claim write only ever targets a slot whose in-use mark was clear.
	a_claim_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == S_EVAL) |-> !rd_use[sel_slot])
		else $error("claim overwrote a page in use");

	// A failed request always reports a zero address.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (claimed_address == '0))
		else $error("failed request with nonzero address");

	// A waiting result is not pushed over an untaken one.
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !out_ready) |=>
		(state_q == S_DONE && out_valid_q))
		else $error("result lost while output stalled");

endmodule

`default_nettype wire
